### sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// shared types and constants of the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int SLOTS     = 16;
   localparam int TIME_BITS = 32;

   localparam int IDX_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   // small decoupling queues on both sides of the engine
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ARM    = 2'd0,
      KIND_DISARM = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  handle;
      logic [31:0] time_req;
   } req_type;

   typedef struct packed {
      logic [3:0] fired_handle;
      logic       fired;
      logic       found;
      logic [4:0] armed_count;
      logic       last;
   } rsp_type;

   // classified command handed from the front queue to the engine
   typedef struct packed {
      kind_type             kind;
      logic [3:0]           handle;
      logic [TIME_BITS-1:0] target;
   } cmd_type;

endpackage

### sv/stq_front.sv
// ----------------------------------------------------------------------------
// stq_front
// request queue: accepts requests and holds them as classified commands
// ----------------------------------------------------------------------------
module stq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  stq_pkg::req_type  req_data,
   output logic              cmd_valid,
   output stq_pkg::cmd_type  cmd,
   input  logic              cmd_take
);

   stq_pkg::cmd_type                 slot_ff [stq_pkg::QDEPTH];
   logic [stq_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stq_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stq_pkg::QCNT_BITS-1:0]    cnt_ff, cnt_in;
   stq_pkg::cmd_type                 new_cmd;
   logic                             do_wr, do_rd;

   assign full      = (cnt_ff == stq_pkg::QCNT_BITS'(stq_pkg::QDEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_wr     = push && !full;
   assign do_rd     = cmd_take && cmd_valid;

   always_comb begin
      new_cmd.kind   = req_data.kind;
      new_cmd.handle = req_data.handle;
      new_cmd.target = stq_pkg::TIME_BITS'(req_data.time_req);
   end

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### sv/stq_rsp_queue.sv
// ----------------------------------------------------------------------------
// stq_rsp_queue
// result queue between the engine and the result ports
// ----------------------------------------------------------------------------
module stq_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  stq_pkg::rsp_type  wr_data,
   output logic              wr_full,
   output logic              empty,
   input  logic              pop,
   output stq_pkg::rsp_type  rsp_data
);

   stq_pkg::rsp_type                 slot_ff [stq_pkg::QDEPTH];
   logic [stq_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stq_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stq_pkg::QCNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                             do_wr, do_rd;

   assign wr_full  = (cnt_ff == stq_pkg::QCNT_BITS'(stq_pkg::QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign do_wr    = wr && !wr_full;
   assign do_rd    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/stq_engine.sv
// ----------------------------------------------------------------------------
// stq_engine
// sorted entry array with per-entry compare cells and the command sequencer
// ----------------------------------------------------------------------------
module stq_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  stq_pkg::cmd_type  cmd,
   output logic              cmd_take,
   output logic              out_wr,
   output stq_pkg::rsp_type  out_data,
   input  logic              out_full
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INSERT = 3'b010,
      ST_POP    = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [stq_pkg::CNT_BITS-1:0]       len_ff, len_in;
   logic [3:0]                         hnd_ff [stq_pkg::SLOTS];
   logic [3:0]                         hnd_in [stq_pkg::SLOTS];
   logic [stq_pkg::TIME_BITS-1:0]      tgt_ff [stq_pkg::SLOTS];
   logic [stq_pkg::TIME_BITS-1:0]      tgt_in [stq_pkg::SLOTS];
   logic [3:0]                         pend_hnd_ff, pend_hnd_in;
   logic [stq_pkg::TIME_BITS-1:0]      pend_tgt_ff, pend_tgt_in;

   logic [3:0]                         hnd_up [stq_pkg::SLOTS];
   logic [stq_pkg::TIME_BITS-1:0]      tgt_up [stq_pkg::SLOTS];
   logic [3:0]                         hnd_dn [stq_pkg::SLOTS];
   logic [stq_pkg::TIME_BITS-1:0]      tgt_dn [stq_pkg::SLOTS];
   logic [stq_pkg::SLOTS-1:0]          match, gone, less, ins_here;
   logic                               found, head_due, next_due;
   logic                               do_shift, pop_all, do_insert;
   logic [stq_pkg::TIME_BITS-1:0]      due_time;

   // neighbor views used for deletion and insertion shifts
   for (genvar g = 0; g < stq_pkg::SLOTS; g++) begin : g_nbr
      if (g == stq_pkg::SLOTS - 1) begin : g_top
         assign hnd_up[g] = hnd_ff[g];
         assign tgt_up[g] = tgt_ff[g];
      end else begin : g_mid
         assign hnd_up[g] = hnd_ff[g+1];
         assign tgt_up[g] = tgt_ff[g+1];
      end
      if (g == 0) begin : g_bot
         assign hnd_dn[g]   = pend_hnd_ff;
         assign tgt_dn[g]   = pend_tgt_ff;
         assign ins_here[g] = !less[g];
      end else begin : g_hi
         assign hnd_dn[g]   = hnd_ff[g-1];
         assign tgt_dn[g]   = tgt_ff[g-1];
         assign ins_here[g] = !less[g] && less[g-1];
      end
      assign match[g] = (stq_pkg::CNT_BITS'(g) < len_ff) && (hnd_ff[g] == cmd.handle);
      assign less[g]  = (stq_pkg::CNT_BITS'(g) < len_ff) && (tgt_ff[g] < pend_tgt_ff);
   end

   // everything from the matching entry upward (on a pop, the whole array) moves down by one
   always_comb begin
      gone[0] = match[0] || pop_all;
      for (int i = 1; i < stq_pkg::SLOTS; i++) begin
         gone[i] = gone[i-1] || match[i];
      end
   end

   assign found    = |match;
   assign due_time = (state_ff == ST_POP) ? pend_tgt_ff : cmd.target;
   assign head_due = (len_ff != '0) && (tgt_ff[0] <= due_time);
   assign next_due = (len_ff > stq_pkg::CNT_BITS'(1)) && (tgt_ff[1] <= pend_tgt_ff);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      pend_hnd_in = pend_hnd_ff;
      pend_tgt_in = pend_tgt_ff;
      cmd_take    = 1'b0;
      out_wr      = 1'b0;
      out_data    = '0;
      do_shift    = 1'b0;
      pop_all     = 1'b0;
      do_insert   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !out_full) begin
               cmd_take = 1'b1;
               unique case (cmd.kind)
                  stq_pkg::KIND_ARM: begin
                     do_shift    = found;
                     len_in      = len_ff - stq_pkg::CNT_BITS'(found);
                     pend_hnd_in = cmd.handle;
                     pend_tgt_in = cmd.target;
                     state_in    = ST_INSERT;
                  end
                  stq_pkg::KIND_DISARM: begin
                     do_shift             = found;
                     len_in               = len_ff - stq_pkg::CNT_BITS'(found);
                     out_wr               = 1'b1;
                     out_data.found       = found;
                     out_data.armed_count = 5'(len_in);
                     out_data.last        = 1'b1;
                  end
                  stq_pkg::KIND_TICK: begin
                     pend_tgt_in = cmd.target;
                     if (head_due) begin
                        state_in = ST_POP;
                     end else begin
                        out_wr               = 1'b1;
                        out_data.armed_count = 5'(len_ff);
                        out_data.last        = 1'b1;
                     end
                  end
                  stq_pkg::KIND_CLEAR: begin
                     len_in        = '0;
                     out_wr        = 1'b1;
                     out_data.last = 1'b1;
                  end
                  default: begin
                     cmd_take = 1'b1;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            if (!out_full) begin
               // a full queue ignores the arm
               if (len_ff < stq_pkg::CNT_BITS'(stq_pkg::SLOTS)) begin
                  do_insert = 1'b1;
                  len_in    = len_ff + 1'b1;
               end
               out_wr               = 1'b1;
               out_data.armed_count = 5'(len_in);
               out_data.last        = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_POP: begin
            if (!out_full) begin
               do_shift              = 1'b1;
               pop_all               = 1'b1;
               len_in                = len_ff - 1'b1;
               out_wr                = 1'b1;
               out_data.fired_handle = hnd_ff[0];
               out_data.fired        = 1'b1;
               out_data.armed_count  = 5'(len_in);
               out_data.last         = !next_due;
               if (!next_due) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < stq_pkg::SLOTS; i++) begin
         hnd_in[i] = hnd_ff[i];
         tgt_in[i] = tgt_ff[i];
         if (do_shift && gone[i]) begin
            hnd_in[i] = hnd_up[i];
            tgt_in[i] = tgt_up[i];
         end else if (do_insert && !less[i]) begin
            // new entry goes ahead of equal targets
            hnd_in[i] = ins_here[i] ? pend_hnd_ff : hnd_dn[i];
            tgt_in[i] = ins_here[i] ? pend_tgt_ff : tgt_dn[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_hnd_ff <= pend_hnd_in;
      pend_tgt_ff <= pend_tgt_in;
      for (int i = 0; i < stq_pkg::SLOTS; i++) begin
         hnd_ff[i] <= hnd_in[i];
         tgt_ff[i] <= tgt_in[i];
      end
   end

endmodule

### sv/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// sorted timer queue: arm, disarm, tick and clear over a sorted entry array
// ----------------------------------------------------------------------------
// Requests enter a two-entry request queue and results leave through a
// two-entry result queue, so both sides may stall independently. The engine
// takes one request at a time: disarm, clear and a tick with nothing due
// finish in the idle state; an arm deletes the old entry, then inserts in
// order; a tick with due timers pops one expired timer per cycle while the
// result queue has room. Each entry has its own compare cells, so a cycle's
// work does not grow with the armed count. Reset needs no clearing pass.
module sorted_timer_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  stq_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output stq_pkg::rsp_type  rsp_data
);

   logic              cmd_valid, cmd_take, out_wr, out_full;
   stq_pkg::cmd_type  cmd;
   stq_pkg::rsp_type  out_data;

   stq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   stq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .out_wr    (out_wr),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   stq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (out_wr),
      .wr_data   (out_data),
      .wr_full   (out_full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_port_checker
// port-level checks of the sorted timer queue
// ----------------------------------------------------------------------------
module stq_port_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              full,
   input  logic              empty,
   input  logic              pop,
   input  stq_pkg::rsp_type  rsp_data
);

   a_reset_empty : assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before it was taken");

   a_no_handle_unfired : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.fired) |-> (rsp_data.fired_handle == 4'd0 && rsp_data.last))
      else $error("result without expiry carries a handle or is not last");

   a_fired_no_found : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.fired) |-> !rsp_data.found)
      else $error("expiry result reports found");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.armed_count <= 5'(stq_pkg::SLOTS)))
      else $error("armed count beyond the number of slots");

endmodule

bind sorted_timer_queue_top stq_port_checker u_stq_port_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
